FILE: rtl/erm_pkg.sv
// Shared constants and types for the Euler angle to rotation matrix pipeline.
`default_nettype none

package erm_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int NUM_LANES    = 3;
	localparam int NUM_ELEMS    = 9;

	// Angle lanes.
	localparam int LANE_H = 0;
	localparam int LANE_P = 1;
	localparam int LANE_R = 2;

	// Matrix element slots, row by row.
	localparam int EL_X0 = 0;
	localparam int EL_X1 = 1;
	localparam int EL_X2 = 2;
	localparam int EL_Y0 = 3;
	localparam int EL_Y1 = 4;
	localparam int EL_Y2 = 5;
	localparam int EL_Z0 = 6;
	localparam int EL_Z1 = 7;
	localparam int EL_Z2 = 8;

	typedef logic signed [33:0] cordic_t;
	typedef logic signed [31:0] q30_t;
	typedef logic signed [33:0] elem_t;

	localparam cordic_t Q30_ONE      = 34'sd1073741824;
	localparam cordic_t HALF_TURN    = 34'sd2147483648;
	localparam cordic_t CORDIC_START = 34'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam cordic_t ATAN_TURNS [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004757, 34'sd42667331,
		34'sd21354465, 34'sd10679838, 34'sd5340247, 34'sd2670163, 34'sd1335087,
		34'sd667544, 34'sd333772, 34'sd166886, 34'sd83443, 34'sd41722,
		34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41,
		34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
	};

	// Sign flip for the folded half plane, then clamp to plus or minus one.
	function automatic q30_t fix_q30(input cordic_t v, input logic flip);
		cordic_t t;
		t = flip ? -v : v;
		if (t > Q30_ONE) begin
			t = Q30_ONE;
		end else if (t < -Q30_ONE) begin
			t = -Q30_ONE;
		end
		return t[31:0];
	endfunction

	// Q1.30 product, rounded half up.
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd536870912;
		return p[61:30];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/euler_to_rotation_matrix.sv
// Top level: pipelined heading, attitude and bank angles to a 3x3 rotation matrix.
`default_nettype none

// Each transaction carries heading, pitch and roll as signed binary angles (half a
// turn is 2^(ANGLE_WIDTH-1)) and yields one rotation matrix of nine signed
// Q1.(ELEMENT_WIDTH-2) elements, clamped to plus or minus one. A transaction is
// taken at every rising edge where start is high; busy is always low, since the
// pipeline never holds and a new transaction may enter in every cycle. There are
// 36 register stages: one capture stage that negates and folds the angles and is
// loaded at the accepting edge itself, thirty CORDIC stages (one rotation step
// each, three lanes side by side), one stage for the sign flip and clamp, two
// product stages (pairs, then the triple products), one stage for the sums and
// one for rounding and clamping into the output registers. The matrix is loaded
// into the output registers once it has passed every stage and is shown on
// m_x0 .. m_z2 for exactly one cycle with done high. The receiver cannot stall
// the block, so results must be taken in the cycle they are shown. No state is
// kept between transactions.
module euler_to_rotation_matrix
	import erm_pkg::*;
#(
	parameter int ANGLE_WIDTH   = 16,
	parameter int ELEMENT_WIDTH = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  signed [ANGLE_WIDTH-1:0]        heading_angle,
	input  wire  signed [ANGLE_WIDTH-1:0]        pitch_angle,
	input  wire  signed [ANGLE_WIDTH-1:0]        roll_angle,
	output logic                                 done,
	output logic signed [ELEMENT_WIDTH-1:0]      m_x0,
	output logic signed [ELEMENT_WIDTH-1:0]      m_x1,
	output logic signed [ELEMENT_WIDTH-1:0]      m_x2,
	output logic signed [ELEMENT_WIDTH-1:0]      m_y0,
	output logic signed [ELEMENT_WIDTH-1:0]      m_y1,
	output logic signed [ELEMENT_WIDTH-1:0]      m_y2,
	output logic signed [ELEMENT_WIDTH-1:0]      m_z0,
	output logic signed [ELEMENT_WIDTH-1:0]      m_z1,
	output logic signed [ELEMENT_WIDTH-1:0]      m_z2
);

	// Output reduction from Q1.30 to Q1.(ELEMENT_WIDTH-2).
	localparam int SHIFT   = 32 - ELEMENT_WIDTH;
	localparam int RND_POS = (SHIFT > 0) ? SHIFT - 1 : 0;
	localparam logic signed [34:0] RND = (SHIFT > 0) ? (35'sd1 <<< RND_POS) : 35'sd0;
	localparam logic signed [34:0] LIM = 35'sd1 <<< (ELEMENT_WIDTH - 2);

	function automatic logic signed [ELEMENT_WIDTH-1:0] to_element(input elem_t v);
		logic signed [34:0] r;
		r = (35'(v) + RND) >>> SHIFT;
		if (r > LIM) begin
			r = LIM;
		end else if (r < -LIM) begin
			r = -LIM;
		end
		return r[ELEMENT_WIDTH-1:0];
	endfunction

	logic                      accept;
	logic [ANGLE_WIDTH-1:0]    ang [NUM_LANES];

	// CORDIC pipeline, index 0 is the capture stage and index k+1 follows step k.
	logic [CORDIC_STEPS:0]     cv_s;
	cordic_t                   cx_s [NUM_LANES][CORDIC_STEPS+1];
	cordic_t                   cy_s [NUM_LANES][CORDIC_STEPS+1];
	cordic_t                   cz_s [NUM_LANES][CORDIC_STEPS+1];
	logic                      cf_s [NUM_LANES][CORDIC_STEPS+1];

	// Cosine and sine of each negated angle.
	logic                      v_s32;
	q30_t                      cos_s32 [NUM_LANES];
	q30_t                      sin_s32 [NUM_LANES];

	// Pair products.
	logic                      v_s33;
	q30_t                      chsa_s33, shsa_s33, chca_s33, shsb_s33, cacb_s33;
	q30_t                      casb_s33, shca_s33, chsb_s33, shcb_s33, chcb_s33;
	q30_t                      sa_s33, sb_s33, cb_s33;

	// Triple products, with the pair products carried along.
	logic                      v_s34;
	q30_t                      chsacb_s34, chsasb_s34, shsacb_s34, shsasb_s34;
	q30_t                      chca_s34, shsb_s34, cacb_s34, casb_s34, shca_s34;
	q30_t                      chsb_s34, shcb_s34, chcb_s34, sa_s34;

	logic                      v_s35;
	elem_t                     elem_s35 [NUM_ELEMS];

	logic                      v_s36;
	logic signed [ELEMENT_WIDTH-1:0] elem_s36 [NUM_ELEMS];

	// The pipeline never holds, so a transaction is taken whenever start is high.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign ang[LANE_H] = heading_angle;
	assign ang[LANE_P] = pitch_angle;
	assign ang[LANE_R] = roll_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s  <= '0;
			v_s32 <= 1'b0;
			v_s33 <= 1'b0;
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
			v_s36 <= 1'b0;
		end else begin
			cv_s  <= {cv_s[CORDIC_STEPS-1:0], accept};
			v_s32 <= cv_s[CORDIC_STEPS];
			v_s33 <= v_s32;
			v_s34 <= v_s33;
			v_s35 <= v_s34;
			v_s36 <= v_s35;
		end
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		logic [ANGLE_WIDTH-1:0] neg;
		logic [31:0]            turn;
		cordic_t                z_raw;
		cordic_t                z_fold;
		logic                   flip;

		// Negate, scale to a 32-bit turn and fold into the right half plane.
		always_comb begin
			neg   = -ang[l];
			turn  = 32'(neg) << (32 - ANGLE_WIDTH);
			z_raw = 34'(signed'(turn));
			flip  = 1'b0;
			z_fold = z_raw;
			if (z_raw > Q30_ONE) begin
				z_fold = z_raw - HALF_TURN;
				flip   = 1'b1;
			end else if (z_raw < -Q30_ONE) begin
				z_fold = z_raw + HALF_TURN;
				flip   = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (accept) begin
				cx_s[l][0] <= CORDIC_START;
				cy_s[l][0] <= '0;
				cz_s[l][0] <= z_fold;
				cf_s[l][0] <= flip;
			end
		end

		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
			always_ff @(posedge clk) begin
				if (cv_s[k]) begin
					if (!cz_s[l][k][33]) begin
						cx_s[l][k+1] <= cx_s[l][k] - (cy_s[l][k] >>> k);
						cy_s[l][k+1] <= cy_s[l][k] + (cx_s[l][k] >>> k);
						cz_s[l][k+1] <= cz_s[l][k] - ATAN_TURNS[k];
					end else begin
						cx_s[l][k+1] <= cx_s[l][k] + (cy_s[l][k] >>> k);
						cy_s[l][k+1] <= cy_s[l][k] - (cx_s[l][k] >>> k);
						cz_s[l][k+1] <= cz_s[l][k] + ATAN_TURNS[k];
					end
					cf_s[l][k+1] <= cf_s[l][k];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cv_s[CORDIC_STEPS]) begin
				cos_s32[l] <= fix_q30(cx_s[l][CORDIC_STEPS], cf_s[l][CORDIC_STEPS]);
				sin_s32[l] <= fix_q30(cy_s[l][CORDIC_STEPS], cf_s[l][CORDIC_STEPS]);
			end
		end
	end

	// First products; each triple product rounds its leading pair here.
	always_ff @(posedge clk) begin
		if (v_s32) begin
			chsa_s33 <= mul_q30(cos_s32[LANE_H], sin_s32[LANE_P]);
			shsa_s33 <= mul_q30(sin_s32[LANE_H], sin_s32[LANE_P]);
			chca_s33 <= mul_q30(cos_s32[LANE_H], cos_s32[LANE_P]);
			shsb_s33 <= mul_q30(sin_s32[LANE_H], sin_s32[LANE_R]);
			cacb_s33 <= mul_q30(cos_s32[LANE_P], cos_s32[LANE_R]);
			casb_s33 <= mul_q30(cos_s32[LANE_P], sin_s32[LANE_R]);
			shca_s33 <= mul_q30(sin_s32[LANE_H], cos_s32[LANE_P]);
			chsb_s33 <= mul_q30(cos_s32[LANE_H], sin_s32[LANE_R]);
			shcb_s33 <= mul_q30(sin_s32[LANE_H], cos_s32[LANE_R]);
			chcb_s33 <= mul_q30(cos_s32[LANE_H], cos_s32[LANE_R]);
			sa_s33   <= sin_s32[LANE_P];
			sb_s33   <= sin_s32[LANE_R];
			cb_s33   <= cos_s32[LANE_R];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s33) begin
			chsacb_s34 <= mul_q30(chsa_s33, cb_s33);
			chsasb_s34 <= mul_q30(chsa_s33, sb_s33);
			shsacb_s34 <= mul_q30(shsa_s33, cb_s33);
			shsasb_s34 <= mul_q30(shsa_s33, sb_s33);
			chca_s34   <= chca_s33;
			shsb_s34   <= shsb_s33;
			cacb_s34   <= cacb_s33;
			casb_s34   <= casb_s33;
			shca_s34   <= shca_s33;
			chsb_s34   <= chsb_s33;
			shcb_s34   <= shcb_s33;
			chcb_s34   <= chcb_s33;
			sa_s34     <= sa_s33;
		end
	end

	// Exact sums in 34 bits; a sum may pass one and is clamped at the output.
	always_ff @(posedge clk) begin
		if (v_s34) begin
			elem_s35[EL_X0] <= 34'(chca_s34);
			elem_s35[EL_X1] <= 34'(shsb_s34) - 34'(chsacb_s34);
			elem_s35[EL_X2] <= -(34'(chsasb_s34) + 34'(shcb_s34));
			elem_s35[EL_Y0] <= 34'(sa_s34);
			elem_s35[EL_Y1] <= 34'(cacb_s34);
			elem_s35[EL_Y2] <= -34'(casb_s34);
			elem_s35[EL_Z0] <= 34'(shca_s34);
			elem_s35[EL_Z1] <= 34'(shsacb_s34) + 34'(chsb_s34);
			elem_s35[EL_Z2] <= 34'(shsasb_s34) + 34'(chcb_s34);
		end
	end

	for (genvar e = 0; e < NUM_ELEMS; e++) begin : g_elem
		always_ff @(posedge clk) begin
			if (v_s35) begin
				elem_s36[e] <= to_element(elem_s35[e]);
			end
		end
	end

	assign done = v_s36;
	assign m_x0 = elem_s36[EL_X0];
	assign m_x1 = elem_s36[EL_X1];
	assign m_x2 = elem_s36[EL_X2];
	assign m_y0 = elem_s36[EL_Y0];
	assign m_y1 = elem_s36[EL_Y1];
	assign m_y2 = elem_s36[EL_Y2];
	assign m_z0 = elem_s36[EL_Z0];
	assign m_z1 = elem_s36[EL_Z1];
	assign m_z2 = elem_s36[EL_Z2];

endmodule

`default_nettype wire

FILE: tb/erm_checker.sv
// Checker for the Euler angle to rotation matrix block: predicts each matrix and compares it.
`timescale 1ns / 100ps

module erm_checker
	import erm_pkg::*;
#(
	parameter int AW = 16,
	parameter int EW = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire          busy,
	input  wire [AW-1:0] heading_angle,
	input  wire [AW-1:0] pitch_angle,
	input  wire [AW-1:0] roll_angle,
	input  wire          done,
	input  wire [EW-1:0] m_x0,
	input  wire [EW-1:0] m_x1,
	input  wire [EW-1:0] m_x2,
	input  wire [EW-1:0] m_y0,
	input  wire [EW-1:0] m_y1,
	input  wire [EW-1:0] m_y2,
	input  wire [EW-1:0] m_z0,
	input  wire [EW-1:0] m_z1,
	input  wire [EW-1:0] m_z2,
	output int           fail_count,
	output int           pending
);

	typedef logic [NUM_ELEMS-1:0][EW-1:0] matrix_t;

	localparam longint ONE_Q30      = 64'sd1073741824;
	localparam longint HALF_Q32     = 64'sd2147483648;
	localparam longint START_GAIN   = 64'sd652032874;
	localparam int     ROTATE_STEPS = 30;

	// Arctangent of 2^-i, in units of 2^-32 of a turn.
	localparam longint STEP_ANGLE [ROTATE_STEPS] = '{
		536870912, 316933406, 167458907, 85004757, 42667331,
		21354465, 10679838, 5340247, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304,
		652, 326, 163, 81, 41,
		20, 10, 5, 3, 1
	};

	string element_name [NUM_ELEMS] = '{
		"m_x0", "m_x1", "m_x2", "m_y0", "m_y1", "m_y2", "m_z0", "m_z1", "m_z2"
	};

	matrix_t matrix_fifo [$];
	matrix_t observed;

	assign observed = {m_z2, m_z1, m_z0, m_y2, m_y1, m_y0, m_x2, m_x1, m_x0};

	function automatic longint saturate(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint q30_product(input longint a, input longint b);
		return (a * b + (ONE_Q30 >>> 1)) >>> 30;
	endfunction

	// Cosine and sine of the negated angle, both in Q1.30.
	function automatic void negated_cos_sin(input logic [AW-1:0] angle,
			output longint c, output longint s);
		logic [AW-1:0] neg;
		logic [31:0]   turn;
		longint        z;
		longint        x;
		longint        y;
		longint        dx;
		longint        dy;
		bit            flip;
		neg  = AW'(0) - angle;
		turn = 32'(neg) << (32 - AW);
		z    = longint'($signed(turn));
		x    = START_GAIN;
		y    = 0;
		flip = 1'b0;
		// Fold the outer half plane onto the inner one and flip the signs later.
		if (z > ONE_Q30) begin
			z    = z - HALF_Q32;
			flip = 1'b1;
		end else if (z < -ONE_Q30) begin
			z    = z + HALF_Q32;
			flip = 1'b1;
		end
		for (int i = 0; i < ROTATE_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - STEP_ANGLE[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + STEP_ANGLE[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = saturate(x, ONE_Q30);
		s = saturate(y, ONE_Q30);
	endfunction

	function automatic logic [EW-1:0] to_element(input longint v);
		int     sh;
		longint r;
		sh = 32 - EW;
		r  = v;
		if (sh > 0)
			r = (v + (longint'(1) << (sh - 1))) >>> sh;
		r = saturate(r, longint'(1) << (EW - 2));
		return r[EW-1:0];
	endfunction

	function automatic matrix_t rotation_from_angles(input logic [AW-1:0] h,
			input logic [AW-1:0] p, input logic [AW-1:0] r);
		longint  ch, sh, ca, sa, cb, sb, chsa, shsa;
		matrix_t m;
		negated_cos_sin(h, ch, sh);
		negated_cos_sin(p, ca, sa);
		negated_cos_sin(r, cb, sb);
		chsa = q30_product(ch, sa);
		shsa = q30_product(sh, sa);
		m[EL_X0] = to_element(q30_product(ch, ca));
		m[EL_X1] = to_element(q30_product(sh, sb) - q30_product(chsa, cb));
		m[EL_X2] = to_element(-(q30_product(chsa, sb) + q30_product(sh, cb)));
		m[EL_Y0] = to_element(sa);
		m[EL_Y1] = to_element(q30_product(ca, cb));
		m[EL_Y2] = to_element(-q30_product(ca, sb));
		m[EL_Z0] = to_element(q30_product(sh, ca));
		m[EL_Z1] = to_element(q30_product(shsa, cb) + q30_product(ch, sb));
		m[EL_Z2] = to_element(q30_product(shsa, sb) + q30_product(ch, cb));
		return m;
	endfunction

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	always @(posedge clk) begin : monitor
		matrix_t wanted;
		if (arst_n) begin
			if (done) begin
				if (matrix_fifo.size() == 0) begin
					$error("matrix result with no transaction outstanding");
					fail_count++;
				end else begin
					wanted = matrix_fifo.pop_front();
					for (int i = 0; i < NUM_ELEMS; i++) begin
						if (observed[i] !== wanted[i]) begin
							$error("%s: expected %0d, actual %0d", element_name[i],
								$signed(wanted[i]), $signed(observed[i]));
							fail_count++;
						end
					end
				end
			end
			if (start && !busy)
				matrix_fifo.push_back(rotation_from_angles(heading_angle, pitch_angle,
					roll_angle));
			pending = matrix_fifo.size();
		end
	end

endmodule

FILE: tb/tb_euler_to_rotation_matrix.sv
// Testbench top for the Euler angle to rotation matrix block: stimulus and verdict.
`timescale 1ns / 100ps

module tb_euler_to_rotation_matrix;

	localparam int AW = 16;
	localparam int EW = 16;

	// Number of random transactions after the directed part.
	localparam int RANDOM_ITEMS = 600;
	// The final stretch of random transactions is sent back to back.
	localparam int STEADY_ITEMS = 100;
	// The drain waits longer than the pipeline takes to show a matrix.
	localparam int DRAIN_CYCLES = 60;
	// The slowest run is about 650 transactions, each after its longest idle burst,
	// plus the drain, so this limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 200000;

	logic          clk           = 1'b0;
	logic          arst_n        = 1'b0;
	logic          start         = 1'b0;
	logic [AW-1:0] heading_angle = '0;
	logic [AW-1:0] pitch_angle   = '0;
	logic [AW-1:0] roll_angle    = '0;

	wire           busy;
	wire           done;
	wire  [EW-1:0] m_x0, m_x1, m_x2, m_y0, m_y1, m_y2, m_z0, m_z1, m_z2;

	int            fail_count;
	int            pending;
	int            cycle_count = 0;

	always #5 clk = ~clk;

	euler_to_rotation_matrix #(
		.ANGLE_WIDTH   (AW),
		.ELEMENT_WIDTH (EW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.heading_angle (heading_angle),
		.pitch_angle   (pitch_angle),
		.roll_angle    (roll_angle),
		.done          (done),
		.m_x0          (m_x0),
		.m_x1          (m_x1),
		.m_x2          (m_x2),
		.m_y0          (m_y0),
		.m_y1          (m_y1),
		.m_y2          (m_y2),
		.m_z0          (m_z0),
		.m_z1          (m_z1),
		.m_z2          (m_z2)
	);

	// The checker sees exactly what the block sees, and it predicts every matrix
	// and compares the results as they come out.
	erm_checker #(
		.AW (AW),
		.EW (EW)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.heading_angle (heading_angle),
		.pitch_angle   (pitch_angle),
		.roll_angle    (roll_angle),
		.done          (done),
		.m_x0          (m_x0),
		.m_x1          (m_x1),
		.m_x2          (m_x2),
		.m_y0          (m_y0),
		.m_y1          (m_y1),
		.m_y2          (m_y2),
		.m_z0          (m_z0),
		.m_z1          (m_z1),
		.m_z2          (m_z2),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Watchdog: a hung handshake or a matrix that never comes ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Presents one transaction and returns at the edge that accepts it. Start is
	// left high, so a following transaction can go out at that same edge without
	// a second assignment to start in this time step.
	task automatic send_angles(input logic [AW-1:0] h, input logic [AW-1:0] p,
			input logic [AW-1:0] r);
		start         <= 1'b1;
		heading_angle <= h;
		pitch_angle   <= p;
		roll_angle    <= r;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drops start for an idle burst of random length.
	task automatic idle_burst();
		start <= 1'b0;
		repeat ($urandom_range(1, 11))
			@(posedge clk);
	endtask

	// Angles for the random part. Half are fully random; the rest sit near the
	// quarter and half turns where the fold and the sign flip change over, near
	// eighth turns, near zero, or at the two ends of the range.
	function automatic logic [AW-1:0] pick_angle();
		logic [AW-1:0] base;
		int            offset;
		case ($urandom_range(0, 9))
			0, 1: begin
				base   = AW'($urandom_range(0, 3)) << (AW - 2);
				offset = int'($urandom_range(0, 16)) - 8;
				return base + AW'(offset);
			end
			2: begin
				base   = AW'($urandom_range(0, 7)) << (AW - 3);
				offset = int'($urandom_range(0, 64)) - 32;
				return base + AW'(offset);
			end
			3: begin
				offset = int'($urandom_range(0, 512)) - 256;
				return AW'(offset);
			end
			4: begin
				case ($urandom_range(0, 3))
					0: return {1'b1, {(AW - 1){1'b0}}};
					1: return {1'b0, {(AW - 1){1'b1}}};
					2: return '1;
					default: return '0;
				endcase
			end
			default: return AW'($urandom);
		endcase
	endfunction

	// Directed angles: zero, both ends of the range, the most negative angle whose
	// negation wraps to itself on each axis alone and on all three, quarter and
	// eighth turns of both signs, plus and minus one, alternating bit patterns, and
	// 45 degree combinations whose element sums round out to the clamp.
	int directed_h [20] = '{
		0, 32767, -32768, -32768, 0, 0, 16384, 0, 0, -16384,
		8192, -8192, 1, -1, 16384, 16385, 21845, -21846, 12345, 8192
	};
	int directed_p [20] = '{
		0, 32767, -32768, 0, -32768, 0, 0, 16384, 0, -16384,
		8192, 8192, -1, 1, 16384, -16385, -21846, 21845, -23456, -8192
	};
	int directed_r [20] = '{
		0, 32767, -32768, 0, 0, -32768, 0, 0, 16384, -16384,
		8192, -8192, 1, -1, 16384, 16383, 21845, -21846, 30000, 8192
	};

	int idle_chance;

	initial begin
		// Reset is held from time zero and released once, at a clock edge.
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (3)
			@(posedge clk);

		// Directed part, with a gap now and then so that some matrices come out
		// back to back and others alone.
		for (int i = 0; i < 20; i++) begin
			if ($urandom_range(0, 2) == 0)
				idle_burst();
			send_angles(AW'(directed_h[i]), AW'(directed_p[i]), AW'(directed_r[i]));
		end

		// Random part. The idle rate changes every 40 transactions, so there are
		// dense stretches as well as sparse ones; the last stretch has no gaps.
		idle_chance = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				idle_chance = $urandom_range(0, 2);
			if (i < RANDOM_ITEMS - STEADY_ITEMS && idle_chance != 0 &&
					$urandom_range(0, 3) < idle_chance)
				idle_burst();
			send_angles(pick_angle(), pick_angle(), pick_angle());
		end
		start <= 1'b0;

		// Drain: every predicted matrix must come out, then a quiet stretch shows
		// whether any extra result follows.
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/erm_pkg.sv
rtl/euler_to_rotation_matrix.sv
tb/erm_checker.sv
tb/tb_euler_to_rotation_matrix.sv
